// ===== rtl/midb_pkg.sv =====
`timescale 1ns / 1ps
package midb_pkg;
  localparam int MaxWidth = 512;
  localparam int MaxHeight = 512;
  localparam int InvFracBits = 24;
  localparam int ColBits = $clog2(MaxWidth);
  localparam int RowBits = $clog2(MaxHeight);
  localparam int AddrBits = ColBits + RowBits;
  localparam int ValBits = InvFracBits + 1;
  localparam int WordBits = ValBits + 1;
  localparam int Depth = MaxWidth * MaxHeight;
  localparam int DivBits = InvFracBits + 1;

  // Division by three as a multiply by ceil(2^29 / 3) and a shift by 29.
  localparam logic [27:0] Div3Mul = 28'hAAAAAAB;
  localparam int Div3Shift = 29;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] REG_PASSES = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [15:0] depth_in;
    logic        depth_in_valid;
  } cmd_t;

  typedef struct packed {
    logic [15:0] depth_out;
    logic        depth_out_valid;
    logic        done_res;
  } res_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DivBits-1:0]   dividend;
    logic [DivBits-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DivBits-1:0]   quotient;
  } div_rsp_t;
endpackage

// ===== rtl/midb_if.sv =====
`timescale 1ns / 1ps
interface midb_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/midb_ram.sv =====
`timescale 1ns / 1ps
module midb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/midb_div.sv =====
`timescale 1ns / 1ps
module midb_div
  import midb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CntBits = $clog2(DivBits + 1);
  logic [DivBits-1:0] quo;
  logic [DivBits-1:0] den;
  logic [DivBits:0]   rem;
  logic [CntBits-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DivBits:0]   trial;
  logic [DivBits:0]   shifted;

  always_comb begin
    shifted = {rem[DivBits-1:0], quo[DivBits-1]};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CntBits'(DivBits);
        quo <= req.dividend;
        den <= req.divisor;
        rem <= '0;
      end else if (busy) begin
        if (!trial[DivBits]) begin
          rem <= trial;
          quo <= {quo[DivBits-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[DivBits-2:0], 1'b0};
        end
        cnt <= cnt - CntBits'(1);
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

// ===== rtl/masked_inverse_depth_box_blur_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Payload
// cmd     | in        | command, col, row, depth_in, depth_in_valid
// res     | out       | depth_out, depth_out_valid, done_res
// cfg     | in        | index (0 passes, 1 width, 2 height), data
// A load, or a read of a valid pixel, presents its result after a 25-step
// restoring division plus the memory access. A read of an invalid or out-of-frame
// pixel skips the division, and an unknown command returns an all-zero result.
// A run makes two visits per pixel and pass, one in each sweep direction. Reset
// clears control state only; the frame memory is undefined until loaded. The
// result register holds while the sink stalls, and no new transaction is taken
// until it is accepted.
module masked_inverse_depth_box_blur_unit
  import midb_pkg::*;
(
  input logic clk,
  input logic rst,
  midb_if.sink   cmd,
  midb_if.source res,
  midb_if.sink   cfg
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LDIV = 4'd1;
  localparam logic [3:0] S_LWR = 4'd2;
  localparam logic [3:0] S_RRD = 4'd3;
  localparam logic [3:0] S_RDIV = 4'd4;
  localparam logic [3:0] S_RDONE = 4'd5;
  localparam logic [3:0] S_BRD = 4'd6;
  localparam logic [3:0] S_BCALC = 4'd7;
  localparam logic [3:0] S_BDIV = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_LDSTART = 4'd10;

  logic [3:0]  state;
  logic [3:0]  blur_passes;
  logic [9:0]  frame_width;
  logic [9:0]  frame_height;
  logic [9:0]  w;
  logic [9:0]  h;
  cmd_t        cur;
  res_t        result;
  logic        res_valid;
  logic [3:0]  pass_counter;
  logic        vert;
  logic [9:0]  line;
  logic [9:0]  pos;
  logic [WordBits-1:0] prev_original;
  logic [WordBits-1:0] cur_word;
  logic [ValBits+1:0]  sum;
  logic [1:0]          cnt;
  logic                dwait;

  logic                ram_we;
  logic [AddrBits-1:0] ram_waddr;
  logic [WordBits-1:0] ram_wdata;
  logic [AddrBits-1:0] ram_raddr;
  logic [WordBits-1:0] ram_rdata;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [9:0]          line_len;
  logic                has_next;
  logic [9:0]          pc;
  logic [9:0]          pr;
  logic [AddrBits-1:0] addr_cur;
  logic [AddrBits-1:0] addr_nxt;
  logic                in_frame;
  logic [ValBits+1:0]  s_all;
  logic [1:0]          n_all;
  logic [WordBits-1:0] nxt_word;
  logic [ValBits+29:0] prod;
  logic [ValBits-1:0]  avg;

  midb_ram #(.Width(WordBits), .Depth(Depth)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
  midb_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    w = (frame_width == 10'd0) ? 10'd1 :
        (frame_width > 10'(MaxWidth)) ? 10'(MaxWidth) : frame_width;
    h = (frame_height == 10'd0) ? 10'd1 :
        (frame_height > 10'(MaxHeight)) ? 10'(MaxHeight) : frame_height;
    in_frame = ({1'b0, cur.col} < w) && ({1'b0, cur.row} < h);
    line_len = vert ? h : w;
    has_next = (pos + 10'd1) < line_len;
    pc = vert ? line : pos;
    pr = vert ? pos : line;
    addr_cur = {pr[RowBits-1:0], pc[ColBits-1:0]};
    addr_nxt = vert ? {pr[RowBits-1:0] + RowBits'(1), pc[ColBits-1:0]}
                    : {pr[RowBits-1:0], pc[ColBits-1:0] + ColBits'(1)};
    nxt_word = has_next ? ram_rdata : '0;
    s_all = '0;
    n_all = '0;
    if (prev_original[WordBits-1]) begin
      s_all = s_all + (ValBits+2)'(prev_original[ValBits-1:0]);
      n_all = n_all + 2'd1;
    end
    if (cur_word[WordBits-1]) begin
      s_all = s_all + (ValBits+2)'(cur_word[ValBits-1:0]);
      n_all = n_all + 2'd1;
    end
    if (nxt_word[WordBits-1]) begin
      s_all = s_all + (ValBits+2)'(nxt_word[ValBits-1:0]);
      n_all = n_all + 2'd1;
    end
    prod = (ValBits+30)'(sum) * (ValBits+30)'(Div3Mul);
    avg = (cnt == 2'd3) ? prod[Div3Shift +: ValBits] :
          (cnt == 2'd2) ? sum[ValBits:1] : sum[ValBits-1:0];

    ram_we = 1'b0;
    ram_waddr = addr_cur;
    ram_wdata = '0;
    ram_raddr = {cur.row[RowBits-1:0], cur.col[ColBits-1:0]};
    dreq = '0;
    unique case (state)
      S_LDSTART: begin
        dreq.start = 1'b1;
        dreq.dividend = DivBits'(1) << InvFracBits;
        dreq.divisor = DivBits'(cur.depth_in);
      end
      S_LWR: begin
        ram_we = in_frame;
        ram_waddr = {cur.row[RowBits-1:0], cur.col[ColBits-1:0]};
        ram_wdata = (cur.depth_in_valid && cur.depth_in != 16'd0) ?
                    {1'b1, drsp.quotient[ValBits-1:0]} : '0;
      end
      S_RDIV: begin
        dreq.start = in_frame && ram_rdata[WordBits-1] &&
                     (ram_rdata[ValBits-1:0] != '0);
        dreq.dividend = DivBits'(1) << InvFracBits;
        dreq.divisor = ram_rdata[ValBits-1:0];
      end
      S_BRD: ram_raddr = addr_cur;
      S_BCALC: ram_raddr = addr_nxt;
      S_BDIV: begin
        if (dwait) begin
          ram_we = 1'b1;
          ram_waddr = addr_cur;
          ram_wdata = (cnt == 2'd0) ? '0 : {1'b1, avg};
        end
      end
      default: ;
    endcase
  end

  assign cmd.ready = (state == S_IDLE) && !res_valid;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;
  assign res.data = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      blur_passes <= 4'd1;
      frame_width <= 10'd512;
      frame_height <= 10'd512;
      pass_counter <= '0;
      prev_original <= '0;
      dwait <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_PASSES: blur_passes <= cfg.data.data[3:0];
          REG_WIDTH: frame_width <= cfg.data.data[9:0];
          REG_HEIGHT: frame_height <= cfg.data.data[9:0];
          default: ;
        endcase
      end
      if (res_valid && res.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            cur <= cmd.data;
            result <= '0;
            unique case (cmd.data.command)
              CMD_LOAD: state <= S_LDSTART;
              CMD_READ: state <= S_RRD;
              CMD_RUN: begin
                pass_counter <= '0;
                vert <= 1'b0;
                line <= '0;
                pos <= '0;
                prev_original <= '0;
                state <= (blur_passes == 4'd0) ? S_OUT : S_BRD;
              end
              default: begin
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_LDSTART: state <= S_LDIV;
        S_LDIV: if (drsp.done) state <= S_LWR;
        S_LWR: state <= S_OUT;
        S_RRD: state <= S_RDIV;
        S_RDIV: begin
          if (!in_frame || !ram_rdata[WordBits-1]) begin
            state <= S_OUT;
          end else if (ram_rdata[ValBits-1:0] == '0) begin
            result.depth_out <= 16'hFFFF;
            result.depth_out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_RDONE;
          end
        end
        S_RDONE: begin
          if (drsp.done) begin
            result.depth_out <= (drsp.quotient > DivBits'(16'hFFFF)) ? 16'hFFFF
                                : drsp.quotient[15:0];
            result.depth_out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_BRD: begin
          state <= S_BCALC;
        end
        S_BCALC: begin
          cur_word <= ram_rdata;
          state <= S_BDIV;
          dwait <= 1'b0;
        end
        S_BDIV: begin
          if (!dwait) begin
            sum <= s_all;
            cnt <= n_all;
            dwait <= 1'b1;
          end else begin
            if (has_next) begin
              prev_original <= cur_word;
              pos <= pos + 10'd1;
              state <= S_BRD;
            end else begin
              pos <= '0;
              prev_original <= '0;
              if (line + 10'd1 < (vert ? w : h)) begin
                line <= line + 10'd1;
                state <= S_BRD;
              end else begin
                line <= '0;
                if (!vert) begin
                  vert <= 1'b1;
                  state <= S_BRD;
                end else begin
                  vert <= 1'b0;
                  if (pass_counter + 4'd1 == blur_passes) begin
                    pass_counter <= '0;
                    state <= S_OUT;
                  end else begin
                    pass_counter <= pass_counter + 4'd1;
                    state <= S_BRD;
                  end
                end
              end
            end
          end
        end
        S_OUT: begin
          result.done_res <= 1'b1;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
